FILE: rtl/pfe_pkg.sv
// Shared types and constants for the palette fade engine.
// No dependencies; imported by palette_fade_engine, palette_fade_checker and the bench.
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int PALETTE_BYTES_DEF = 768;
  localparam int IDX_W             = 10;
  localparam int VAL_W             = 8;
  localparam logic [VAL_W-1:0] STEP_SIZE_RST = 8'd2;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_CLEAR    = 3'd1,
    KIND_FADE_IN  = 3'd2,
    KIND_FADE_OUT = 3'd3,
    KIND_READ     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/palette_fade_engine.sv
// Palette fade engine top level: target and displayed palette memories plus sweep control.
// Depends on pfe_pkg.
`timescale 1ns / 1ps

// Holds a target palette and a displayed palette of PALETTE_BYTES bytes each, in two
// single-write, single-read memories with registered read data. One beat in gives one
// beat out. A target write, a displayed read or an unused kind goes from acceptance to
// ST_FINISH, which loads the result register once it is free, and then back to ST_IDLE to
// take the next beat. Clear, fade-in and fade-out walk every entry through a read /
// modify / write-back pipeline, one entry a cycle, then pass through ST_FINISH to the
// result register before the next beat is taken. After reset a clearing pass zeroes
// the displayed palette; no beat is taken meanwhile, configuration writes are.
// The finished result sits in an output register, so the next beat is taken while it
// waits to be taken.
module palette_fade_engine #(
  parameter int PALETTE_BYTES = pfe_pkg::PALETTE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,      // step size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,       // entry_index[9:0], entry_value[17:10], zero pad
  input  logic [2:0]  in_tuser,       // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata       // changed[0], read_value[8:1], zero pad
);
  import pfe_pkg::*;

  localparam int ADDR_W = (PALETTE_BYTES > 1) ? $clog2(PALETTE_BYTES) : 1;
  localparam int CNT_W  = $clog2(PALETTE_BYTES + 1);
  localparam int XW     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PALETTE_BYTES);
  localparam logic [XW-1:0]    DEPTH_X  = XW'(PALETTE_BYTES);

  logic [VAL_W-1:0] target_mem [PALETTE_BYTES];
  logic [VAL_W-1:0] shown_mem  [PALETTE_BYTES];

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              wb_vld_r, wb_vld_nxt;
  logic [ADDR_W-1:0] wb_addr_r, wb_addr_nxt;
  logic              any_r, any_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [VAL_W-1:0]  step_size_r;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic              out_changed_r, out_changed_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;

  logic              tgt_we, tgt_re;
  logic [ADDR_W-1:0] tgt_waddr, rd_addr;
  logic [VAL_W-1:0]  tgt_q, shown_q;
  logic              shown_we, shown_re;
  logic [VAL_W-1:0]  shown_wdata;

  logic              in_acc;
  kind_t             in_kind;
  logic [XW-1:0]     in_idx_x;
  logic              in_range;
  logic              eligible;
  logic [VAL_W-1:0]  new_val;
  logic [VAL_W:0]    up_sum;

  assign in_acc   = in_tvalid && in_tready;
  assign in_kind  = kind_t'(in_tuser);
  assign in_idx_x = XW'(in_tdata[IDX_W-1:0]);
  assign in_range = in_idx_x < DEPTH_X;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_value_r, out_changed_r};

  // target memory: written by target beats, read during sweeps
  assign tgt_we    = in_acc && (in_kind == KIND_WRITE) && in_range;
  assign tgt_waddr = in_idx_x[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      target_mem[tgt_waddr] <= in_tdata[IDX_W +: VAL_W];
    end
    if (tgt_re) begin
      tgt_q <= target_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (shown_we) begin
      shown_mem[wb_addr_r] <= shown_wdata;
    end
    if (shown_re) begin
      shown_q <= shown_mem[rd_addr];
    end
  end

  // per-entry update in the write-back stage
  assign up_sum = {1'b0, shown_q} + {1'b0, step_size_r};

  always_comb begin
    eligible = 1'b0;
    new_val  = '0;
    unique case (kind_r)
      KIND_FADE_IN: begin
        eligible = (shown_q != tgt_q);
        new_val  = shown_q;
        if (eligible) begin
          new_val = (up_sum < {1'b0, tgt_q}) ? up_sum[VAL_W-1:0] : tgt_q;
        end
      end
      KIND_FADE_OUT: begin
        eligible = (shown_q != '0);
        new_val  = (shown_q > step_size_r) ? shown_q - step_size_r : '0;
      end
      default: begin
        eligible = 1'b0;
        new_val  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= STEP_SIZE_RST;
    end else if (cfg_we) begin
      step_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      kind_r       <= KIND_CLEAR;
      cnt_r        <= '0;
      wb_vld_r     <= 1'b0;
      any_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kind_r       <= kind_nxt;
      cnt_r        <= cnt_nxt;
      wb_vld_r     <= wb_vld_nxt;
      any_r        <= any_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r     <= wb_addr_nxt;
    rd_ok_r       <= rd_ok_nxt;
    out_changed_r <= out_changed_nxt;
    out_value_r   <= out_value_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    cnt_nxt         = cnt_r;
    wb_vld_nxt      = 1'b0;
    wb_addr_nxt     = wb_addr_r;
    any_nxt         = any_r;
    rd_ok_nxt       = rd_ok_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_changed_nxt = out_changed_r;
    out_value_nxt   = out_value_r;
    tgt_re          = 1'b0;
    shown_re        = 1'b0;
    shown_we        = 1'b0;
    shown_wdata     = new_val;
    rd_addr         = cnt_r[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_kind;
          cnt_nxt   = '0;
          any_nxt   = 1'b0;
          rd_ok_nxt = in_range;
          if ((in_kind == KIND_CLEAR) || (in_kind == KIND_FADE_IN) ||
              (in_kind == KIND_FADE_OUT)) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_FINISH;
          end
          if ((in_kind == KIND_READ) && in_range) begin
            shown_re = 1'b1;
            rd_addr  = in_idx_x[ADDR_W-1:0];
          end
        end
      end
      ST_INIT, ST_SWEEP: begin
        if (cnt_r != LAST_CNT) begin
          tgt_re      = 1'b1;
          shown_re    = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          wb_vld_nxt  = 1'b1;
          wb_addr_nxt = cnt_r[ADDR_W-1:0];
        end else begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_FINISH;
        end
        if (wb_vld_r) begin
          shown_we = 1'b1;
          any_nxt  = any_r || eligible;
        end
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt  = 1'b1;
          out_changed_nxt = any_r &&
                            ((kind_r == KIND_FADE_IN) || (kind_r == KIND_FADE_OUT));
          out_value_nxt   = ((kind_r == KIND_READ) && rd_ok_r) ? shown_q : '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // write-back stage always follows a read of the same entry in the previous cycle
  a_wb_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> ($past(shown_re) && ($past(rd_addr) == wb_addr_r)))
    else $error("write-back without matching read");

  a_we_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    shown_we |-> ((state_r == ST_SWEEP) || (state_r == ST_INIT)))
    else $error("displayed palette written outside a sweep");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside finish");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_CNT)
    else $error("sweep counter past palette size");

  a_sweep_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SWEEP) && (state_nxt == ST_FINISH)) |=> !wb_vld_r)
    else $error("sweep ended with a write-back pending");

endmodule

FILE: tb/palette_fade_checker.sv
// Scoreboard for palette_fade_engine: snoops the config port and both streams, keeps its
// own copy of both palettes and compares every result beat. Depends on pfe_pkg.
`timescale 1ns / 1ps

module palette_fade_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          mismatches,
  output int          pending
);
  import pfe_pkg::*;

  localparam int ENTRIES = PALETTE_BYTES_DEF;

  typedef struct packed {
    logic             changed;
    logic [VAL_W-1:0] read_value;
  } fade_result_t;

  logic [VAL_W-1:0] goal_pal [ENTRIES];
  logic [VAL_W-1:0] lit_pal  [ENTRIES];
  logic [VAL_W-1:0] step_amt;
  fade_result_t     results_due [$];
  int               err_cnt = 0;

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic fade_result_t predict_beat(logic [2:0] kind, int idx,
                                                logic [VAL_W-1:0] val);
    fade_result_t r;
    logic [VAL_W:0] up;
    r = '0;
    case (kind)
      KIND_WRITE: begin
        if (idx < ENTRIES) goal_pal[idx] = val;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) lit_pal[i] = '0;
      end
      KIND_FADE_IN: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (lit_pal[i] != goal_pal[i]) begin
            r.changed = 1'b1;
            up = {1'b0, lit_pal[i]} + {1'b0, step_amt};
            lit_pal[i] = (up < {1'b0, goal_pal[i]}) ? up[VAL_W-1:0] : goal_pal[i];
          end
        end
      end
      KIND_FADE_OUT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (lit_pal[i] != '0) begin
            r.changed = 1'b1;
            lit_pal[i] = (lit_pal[i] > step_amt) ? lit_pal[i] - step_amt : '0;
          end
        end
      end
      KIND_READ: begin
        if (idx < ENTRIES) r.read_value = lit_pal[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    fade_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        goal_pal[i] = '0;
        lit_pal[i]  = '0;
      end
      step_amt = STEP_SIZE_RST;
      results_due.delete();
    end else begin
      if (cfg_we === 1'b1) step_amt = cfg_wdata;
      // drain side first so a stray beat never pairs with this edge's input
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%04h with none due", out_tdata));
        end else begin
          want = results_due.pop_front();
          if (out_tdata[0] !== want.changed)
            report_mismatch($sformatf("changed: expected %0d got %0b",
                                      want.changed, out_tdata[0]));
          if (out_tdata[8:1] !== want.read_value)
            report_mismatch($sformatf("read_value: expected %0d got %0d",
                                      want.read_value, out_tdata[8:1]));
        end
      end
      if (in_tvalid === 1'b1 && in_tready === 1'b1)
        results_due.push_back(predict_beat(in_tuser, int'(in_tdata[IDX_W-1:0]),
                                           in_tdata[IDX_W+VAL_W-1:IDX_W]));
    end
    pending    <= results_due.size();
    mismatches <= err_cnt;
  end

endmodule

FILE: tb/palette_fade_engine_tb.sv
// Top of the palette_fade_engine bench: clock, reset, stimulus and verdict.
// Depends on pfe_pkg, palette_fade_engine and palette_fade_checker.
`timescale 1ns / 1ps

module palette_fade_engine_tb;
  import pfe_pkg::*;

  localparam logic [2:0]  KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;
  localparam int          NUM_PHASES     = 6;
  localparam int          PHASE_ITEMS    = 8;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          TAIL_CYCLES    = 20;
  localparam int          STALL_LIMIT    = 20000;
  localparam int          TX_CALM_LO     = 400;
  localparam int          TX_CALM_HI     = 560;
  localparam int          RX_HOLD_AT     = 200;
  localparam int          RX_HOLD_CYCLES = 3000;
  localparam int          RX_CALM_LO     = 500;
  localparam int          RX_CALM_HI     = 680;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  int          mismatches;
  int          pending;
  int          beats_sent = 0;
  int          quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  palette_fade_engine #(
    .PALETTE_BYTES(PALETTE_BYTES_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  palette_fade_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  function automatic int pick_index();
    if ($urandom_range(99) < 10) return $urandom_range(1023);
    return $urandom_range(PALETTE_BYTES_DEF - 1);
  endfunction

  function automatic int pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 0;
    if (roll < 16) return 255;
    return $urandom_range(255);
  endfunction

  task automatic send_item(logic [2:0] kind, int idx, int val);
    bit calm;
    calm = (beats_sent >= TX_CALM_LO) && (beats_sent < TX_CALM_HI);
    while (!calm && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, val[VAL_W-1:0], idx[IDX_W-1:0]};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_episode();
    int n;
    if ($urandom_range(99) < 20) send_item(KIND_CLEAR, pick_index(), pick_value());
    n = $urandom_range(6);
    repeat (n) send_item(KIND_WRITE, pick_index(), pick_value());
    n = $urandom_range(4, 1);
    repeat (n) send_item(KIND_FADE_IN, pick_index(), pick_value());
    n = $urandom_range(4);
    repeat (n) send_item(KIND_READ, pick_index(), pick_value());
    n = $urandom_range(3);
    repeat (n) send_item(KIND_FADE_OUT, pick_index(), pick_value());
    n = $urandom_range(3);
    repeat (n) send_item(KIND_READ, pick_index(), pick_value());
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: send_item(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)),
                     $urandom_range(1023), $urandom_range(255));
        1: send_item(KIND_WRITE, $urandom_range(1023, PALETTE_BYTES_DEF), pick_value());
        2: send_item(KIND_READ, $urandom_range(1023, PALETTE_BYTES_DEF), pick_value());
        default: send_item(KIND_FADE_OUT, pick_index(), pick_value());
      endcase
    end
  endtask

  // receiver: random backpressure, one long hold-off, one calm window
  initial begin
    int unsigned taken;
    bit held;
    taken = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) taken++;
      if (!held && taken >= RX_HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      if (taken >= RX_CALM_LO && taken < RX_CALM_HI) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_start;
    int amt;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_WRITE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every target entry gets written before the first fade-in
    for (int i = 0; i < PALETTE_BYTES_DEF; i++)
      send_item(KIND_WRITE, i, pick_value());

    // directed, reset fade amount
    send_item(KIND_WRITE, 0, 255);
    send_item(KIND_WRITE, PALETTE_BYTES_DEF - 1, 0);
    send_item(KIND_WRITE, PALETTE_BYTES_DEF, 170);
    send_item(KIND_WRITE, 1023, 85);
    send_item(KIND_READ, PALETTE_BYTES_DEF, 0);
    send_item(KIND_READ, 1023, 255);
    send_item(KIND_READ, 0, 0);
    send_item(KIND_FADE_OUT, 0, 0);
    send_item(KIND_FADE_IN, 0, 0);
    send_item(KIND_READ, 0, 0);
    send_item(KIND_READ, PALETTE_BYTES_DEF - 1, 0);
    send_item(KIND_FADE_IN, 0, 0);
    send_item(KIND_WRITE, 0, 1);
    send_item(KIND_FADE_IN, 1023, 255);
    send_item(KIND_READ, 0, 0);
    send_item(KIND_FADE_OUT, 0, 0);
    send_item(KIND_READ, 0, 0);
    send_item(KIND_SPARE_LO, 0, 0);
    send_item(KIND_SPARE_HI, 1023, 255);
    send_item(KIND_CLEAR, 0, 0);
    send_item(KIND_READ, 1, 0);
    send_item(KIND_FADE_IN, 0, 0);
    send_item(KIND_CLEAR, 1023, 255);
    send_item(KIND_FADE_OUT, 0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: amt = 255;
        1: amt = 1;
        2: amt = 0;
        5: amt = 128;
        default: amt = $urandom_range(254, 1);
      endcase
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= amt[7:0];
      @(posedge clk);
      cfg_we    <= 1'b0;
      if (p == 0) begin
        // full-strength fade reaches every target, second step reports no change
        send_item(KIND_CLEAR, 0, 0);
        send_item(KIND_FADE_IN, 0, 0);
        send_item(KIND_FADE_IN, 0, 0);
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_ITEMS) run_episode();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pfe_pkg.sv
rtl/palette_fade_engine.sv
tb/palette_fade_checker.sv
tb/palette_fade_engine_tb.sv
